// ===== src/ncc_pkg.sv =====
package ncc_pkg;

    // configuration port
    localparam int CFG_DATA_W = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_W     = 32;
    localparam int PACK_W     = 32;
    localparam int COLS_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUTOFF_SQ   = 3'd0,
        REG_CENTER_GRP  = 3'd1,
        REG_NEIGHBOR_GRP= 3'd2,
        REG_COLUMNS     = 3'd3,
        REG_TYPE_LOW    = 3'd4,
        REG_TYPE_HIGH   = 3'd5
    } ncc_cfg_idx_t;

    // distance datapath
    localparam int EXT_W  = 33;                 // holds |diff| for coordinates up to 32 bits
    localparam int MAG_W  = 26;                 // clamped magnitude, up to 2^25
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam logic [EXT_W-1:0] DIFF_CLAMP = 33'h0_0200_0000;

    // result word
    localparam int OUT_COLS    = 4;
    localparam int OUT_CNT_W   = 10;
    localparam int OUT_CNT_MAX = 1023;
    localparam int CNT_EXT_W   = 16;
    localparam int OUT_DATA_W  = 48;

    typedef struct packed {
        logic upd;      // item leaves the distance stage this cycle
        logic count;    // item is eligible and inside the cutoff
        logic last;     // final item of the centre atom
    } ncc_ctl_t;

endpackage

// ===== src/ncc_mag.sv =====
module ncc_mag #(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    output logic [ncc_pkg::MAG_W-1:0]    mag
);
    import ncc_pkg::*;

    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]        abs_diff;
    logic [EXT_W-1:0]           wide;

    always_comb
    begin
        diff     = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        abs_diff = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
        wide     = EXT_W'(abs_diff);
        // anything clamped squares past the widest cutoff
        mag = (wide > DIFF_CLAMP) ? DIFF_CLAMP[MAG_W-1:0] : wide[MAG_W-1:0];
    end

endmodule

// ===== src/ncc_col_bank.sv =====
module ncc_col_bank #(
    parameter int NUM_COLUMNS = 4,
    parameter int COUNT_BITS  = 10
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ncc_pkg::ncc_ctl_t                         ctl,
    input  logic [NUM_COLUMNS-1:0]                    col_hit,
    output logic [NUM_COLUMNS-1:0][COUNT_BITS-1:0]    counts_now
);
    import ncc_pkg::*;

    logic [NUM_COLUMNS-1:0][COUNT_BITS-1:0] counts_reg;
    logic [NUM_COLUMNS-1:0][COUNT_BITS-1:0] counts_next;

    always_comb
    begin
        for (int m = 0; m < NUM_COLUMNS; m++)
        begin
            // saturating increment
            counts_now[m] = counts_reg[m] + COUNT_BITS'(ctl.count && col_hit[m]
                                                       && (counts_reg[m] != '1));
            if (!ctl.upd)
                counts_next[m] = counts_reg[m];
            else if (ctl.last)
                counts_next[m] = '0;
            else
                counts_next[m] = counts_now[m];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counts_reg <= '0;
        else
            counts_reg <= counts_next;
    end

endmodule

// ===== src/neighbor_coordination_counter_unit.sv =====
// Coordination-number counter.
// s_* carries one word per neighbor-list entry: centre and neighbor coordinates
// (signed fixed point, 12 fraction bits), both group masks and the neighbor
// type; tuser flags a real neighbor, tlast marks the centre's final entry.
// A neighbor counts in column m when its mask meets the neighbor group, the
// centre is in the centre group, its squared distance is below the cutoff and
// its type lies in column m's inclusive range. Counts saturate.
// m_* emits one word per centre atom, on its tlast entry: four 10-bit counts
// and a centre-counted flag; counts then clear. An empty list is sent as one
// entry with tuser low and tlast high.
// cfg_* writes registers by index; the user writes only while no atom is in
// flight, which the block does not enforce. A tlast word passes the input
// register and the square register, then loads the result register (m_tvalid).
// One word per cycle while s_tready is high; the only loop is the counter update
// in the last stage. Reset clears pipeline, counts and registers to defaults.
// When m_tready is low the result stays in the output register; words without
// tlast keep flowing. A second tlast word then waits in the square register,
// one more word fills the input register, and after that s_tready drops.
module neighbor_coordination_counter_unit #(
    parameter int NUM_COLUMNS = 4,
    parameter int COORD_BITS  = 24,
    parameter int COUNT_BITS  = 10,
    parameter int TYPE_BITS   = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // lowest bit up: center_x, center_y, center_z, center_mask, neighbor_x,
    // neighbor_y, neighbor_z, neighbor_mask, neighbor_type, zero fill
    input  logic [((6*COORD_BITS+64+TYPE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                 s_tuser,   // neighbor_valid
    input  logic                                 s_tlast,   // last_neighbor
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // lowest bit up: count_col0..count_col3, center_counted, zero fill
    output logic [ncc_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [ncc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ncc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ncc_pkg::*;

    localparam int OFF_CX = 0;
    localparam int OFF_CY = COORD_BITS;
    localparam int OFF_CZ = 2 * COORD_BITS;
    localparam int OFF_CM = 3 * COORD_BITS;
    localparam int OFF_NX = 3 * COORD_BITS + MASK_W;
    localparam int OFF_NY = 4 * COORD_BITS + MASK_W;
    localparam int OFF_NZ = 5 * COORD_BITS + MASK_W;
    localparam int OFF_NM = 6 * COORD_BITS + MASK_W;
    localparam int OFF_NT = 6 * COORD_BITS + 2 * MASK_W;

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] cutoff_sq_reg;
    logic [MASK_W-1:0]     center_grp_reg;
    logic [MASK_W-1:0]     neighbor_grp_reg;
    logic [COLS_W-1:0]     columns_used_reg;
    logic [PACK_W-1:0]     type_low_reg;
    logic [PACK_W-1:0]     type_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_sq_reg    <= '0;
            center_grp_reg   <= MASK_W'(1);
            neighbor_grp_reg <= MASK_W'(1);
            columns_used_reg <= COLS_W'(1);
            type_low_reg     <= PACK_W'(1);
            type_high_reg    <= PACK_W'(255);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CUTOFF_SQ:    cutoff_sq_reg    <= cfg_data;
                REG_CENTER_GRP:   center_grp_reg   <= cfg_data[MASK_W-1:0];
                REG_NEIGHBOR_GRP: neighbor_grp_reg <= cfg_data[MASK_W-1:0];
                REG_COLUMNS:      columns_used_reg <= cfg_data[COLS_W-1:0];
                REG_TYPE_LOW:     type_low_reg     <= cfg_data[PACK_W-1:0];
                REG_TYPE_HIGH:    type_high_reg    <= cfg_data[PACK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake chain ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s2_last_reg;
    logic out_free, s2_fire, s2_free, s1_fire, in_fire;

    assign out_free = !out_valid_reg || m_tready;
    // only a tlast word needs room in the output register
    assign s2_fire  = s2_valid_reg && (!s2_last_reg || out_free);
    assign s2_free  = !s2_valid_reg || s2_fire;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;

    // ---------------- front: magnitudes, masks, type ranges ----------------
    logic [2:0][MAG_W-1:0]  mag_in;
    logic [NUM_COLUMNS-1:0] match_in;
    logic                   centre_in, eligible_in;
    logic [TYPE_BITS-1:0]   ntype;

    ncc_mag #(.COORD_BITS(COORD_BITS)) u_mag_x (
        .a   (s_tdata[OFF_CX +: COORD_BITS]),
        .b   (s_tdata[OFF_NX +: COORD_BITS]),
        .mag (mag_in[0])
    );
    ncc_mag #(.COORD_BITS(COORD_BITS)) u_mag_y (
        .a   (s_tdata[OFF_CY +: COORD_BITS]),
        .b   (s_tdata[OFF_NY +: COORD_BITS]),
        .mag (mag_in[1])
    );
    ncc_mag #(.COORD_BITS(COORD_BITS)) u_mag_z (
        .a   (s_tdata[OFF_CZ +: COORD_BITS]),
        .b   (s_tdata[OFF_NZ +: COORD_BITS]),
        .mag (mag_in[2])
    );

    assign ntype       = s_tdata[OFF_NT +: TYPE_BITS];
    assign centre_in   = (s_tdata[OFF_CM +: MASK_W] & center_grp_reg) != '0;
    assign eligible_in = centre_in && s_tuser
                         && ((s_tdata[OFF_NM +: MASK_W] & neighbor_grp_reg) != '0);

    for (genvar m = 0; m < NUM_COLUMNS; m++)
    begin : g_range
        if ((m + 1) * TYPE_BITS <= PACK_W)
        begin : g_fit
            localparam logic [COLS_W:0] COL_NUM = (COLS_W+1)'(m);
            assign match_in[m] = (COL_NUM < {1'b0, columns_used_reg})
                && (ntype >= type_low_reg[m*TYPE_BITS +: TYPE_BITS])
                && (ntype <= type_high_reg[m*TYPE_BITS +: TYPE_BITS]);
        end
        else
        begin : g_nofit
            // bounds do not fit the packed register
            assign match_in[m] = 1'b0;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [2:0][MAG_W-1:0]  s1_mag_reg;
    logic [NUM_COLUMNS-1:0] s1_match_reg;
    logic                   s1_centre_reg, s1_elig_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mag_reg    <= mag_in;
            s1_match_reg  <= match_in;
            s1_centre_reg <= centre_in;
            s1_elig_reg   <= eligible_in;
            s1_last_reg   <= s_tlast;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic [2:0][SQ_W-1:0]   sq_in;
    logic [2:0][SQ_W-1:0]   s2_sq_reg;
    logic [NUM_COLUMNS-1:0] s2_match_reg;
    logic                   s2_centre_reg, s2_elig_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sq_in[k] = s1_mag_reg[k] * s1_mag_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_sq_reg     <= sq_in;
            s2_match_reg  <= s1_match_reg;
            s2_centre_reg <= s1_centre_reg;
            s2_elig_reg   <= s1_elig_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // ---------------- stage 3: cutoff compare and counters ----------------
    logic [SUM_W-1:0] rsq;
    ncc_ctl_t         ctl;
    logic [NUM_COLUMNS-1:0][COUNT_BITS-1:0] counts_now;

    assign rsq = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);

    always_comb
    begin
        ctl.upd   = s2_fire;
        ctl.count = s2_elig_reg && (rsq < SUM_W'(cutoff_sq_reg));
        ctl.last  = s2_last_reg;
    end

    ncc_col_bank #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_col_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .col_hit    (s2_match_reg),
        .counts_now (counts_now)
    );

    // result word: counts clamp to the 10-bit field, absent columns read zero
    logic [OUT_COLS-1:0][OUT_CNT_W-1:0] col_out;

    for (genvar m = 0; m < OUT_COLS; m++)
    begin : g_out
        if (m < NUM_COLUMNS)
        begin : g_present
            logic [CNT_EXT_W-1:0] ext;
            assign ext = CNT_EXT_W'(counts_now[m]);
            assign col_out[m] = !s2_centre_reg ? '0 :
                                (ext > CNT_EXT_W'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX) :
                                ext[OUT_CNT_W-1:0];
        end
        else
        begin : g_absent
            assign col_out[m] = '0;
        end
    end

    // ---------------- output register ----------------
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_fire && s2_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && s2_last_reg)
            out_data_reg <= OUT_DATA_W'({s2_centre_reg, col_out});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a centre outside its group reports all counts as zero
    a_zero_when_uncounted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[OUT_COLS*OUT_CNT_W]) |-> (m_tdata[OUT_COLS*OUT_CNT_W-1:0] == '0))
        else $error("uncounted centre reported nonzero counts");

    // a tlast word blocked by a full output register stays in stage 2
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg && !out_free) |=> (s2_valid_reg && s2_last_reg))
        else $error("final word dropped while output stalled");
`endif

endmodule
